// ----- src/heightmap_column_wall_extent_macros.svh -----
// Assertion macros for the heightmap column wall extent block.
// Included by the top level; depends on nothing else.
`ifndef HEIGHTMAP_COLUMN_WALL_EXTENT_MACROS_SVH
`define HEIGHTMAP_COLUMN_WALL_EXTENT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HCWE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define HCWE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/hcwe_pkg.sv -----
// Shared types and constants for the heightmap column wall extent block.
// No dependencies.
`timescale 1ns / 1ps

package hcwe_pkg;

   // input opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   // register indexes
   localparam logic [1:0] REG_MAP_WIDTH    = 2'd0;
   localparam logic [1:0] REG_MAP_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

   // register reset values
   localparam logic [10:0] MAP_WIDTH_RESET    = 11'd1024;
   localparam logic [10:0] MAP_HEIGHT_RESET   = 11'd1024;
   localparam logic [7:0]  HEIGHT_SCALE_RESET = 8'd128;

   // row count limit
   localparam logic [10:0] ROW_LIMIT = 11'd1024;

   // material codes
   localparam logic [1:0] MAT_GRASS = 2'd0;
   localparam logic [1:0] MAT_DIRT  = 2'd1;
   localparam logic [1:0] MAT_STONE = 2'd2;

   localparam logic [7:0] STONE_LEVEL = 8'd100;

   // 3x3 window, index col * 3 + row; col 2 newest, row 2 lowest
   typedef logic [8:0][7:0] hcwe_window_type;

   // which window edges fall outside the map
   typedef struct packed {
      logic skip_left;
      logic skip_right;
      logic skip_top;
      logic skip_bottom;
   } hcwe_border_type;

endpackage

// ----- src/hcwe_column_eval.sv -----
// Column evaluation: clipped 3x3 minimum and surface material.
// Depends on hcwe_pkg.
`timescale 1ns / 1ps

module hcwe_column_eval (
   input  hcwe_pkg::hcwe_window_type window,
   input  hcwe_pkg::hcwe_border_type border,
   output logic [7:0]                surface_height,
   output logic [7:0]                wall_bottom,
   output logic [1:0]                top_material
);
   import hcwe_pkg::*;

   assign surface_height = window[4];

   // minimum over in-map window cells, centre included
   always_comb begin
      logic [7:0] least;
      logic       use_cell;
      least = window[4];
      for (int dc = 0; dc < 3; dc++) begin
         for (int dr = 0; dr < 3; dr++) begin
            use_cell = 1'b1;
            if (dc == 0 && border.skip_left)   use_cell = 1'b0;
            if (dc == 2 && border.skip_right)  use_cell = 1'b0;
            if (dr == 0 && border.skip_top)    use_cell = 1'b0;
            if (dr == 2 && border.skip_bottom) use_cell = 1'b0;
            if (use_cell && window[dc * 3 + dr] < least) least = window[dc * 3 + dr];
         end
      end
      wall_bottom = least;
   end

   // material of the surface voxel
   always_comb begin
      if (window[4] < STONE_LEVEL)       top_material = MAT_GRASS;
      else if (window[4] == STONE_LEVEL) top_material = MAT_DIRT;
      else                               top_material = MAT_STONE;
   end

endmodule

// ----- src/heightmap_column_wall_extent.sv -----
// Heightmap column wall extent: line-buffered 3x3 erosion over scaled heights.
// Depends on hcwe_pkg, hcwe_column_eval and the macros header.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    opcode, height_sample
//   rsp      out        rsp_valid/rsp_ready    col_x, row_z, surface_height,
//                                              wall_bottom, top_material, frame_last
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One word per cycle sustained unless the result register stalls; a result
// leaves through the row buffer read register, then the result register,
// and lags the input by one row plus one word. Synchronous reset clears
// counters, window and registers; row buffers are not cleared. A stalled
// result register stalls the input; the csr port is always ready.
`timescale 1ns / 1ps
`include "heightmap_column_wall_extent_macros.svh"

module heightmap_column_wall_extent #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_height_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_col_x,
   output logic [9:0]  rsp_row_z,
   output logic [7:0]  rsp_surface_height,
   output logic [7:0]  rsp_wall_bottom,
   output logic [1:0]  rsp_top_material,
   output logic        rsp_frame_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);
   import hcwe_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);

   // configuration
   logic [10:0] map_width_ff, map_height_ff;
   logic [7:0]  height_scale_ff;
   logic [WW-1:0] w_eff;
   logic [10:0]   h_eff;

   // counters
   logic [CW-1:0] col_ff, out_col_ff;
   logic [10:0]   row_ff;
   logic [9:0]    out_row_ff;

   // row buffers
   logic [7:0] prev_mem  [MAX_WIDTH];
   logic [7:0] older_mem [MAX_WIDTH];
   logic [7:0] prev_rd_ff, older_rd_ff;

   // stage A
   logic            a_valid_ff, a_primed_ff, a_last_ff, a_fwd_ff;
   logic [CW-1:0]   a_col_ff;
   logic [7:0]      a_v_ff, a_fwd_data_ff;
   logic [9:0]      a_x_ff, a_z_ff;
   hcwe_border_type a_border_ff, border_in;

   // window and result
   hcwe_window_type window_ff, window_in;
   logic       rsp_valid_ff, rsp_frame_last_ff;
   logic [9:0] rsp_col_x_ff, rsp_row_z_ff;
   logic [7:0] rsp_surface_height_ff, rsp_wall_bottom_ff;
   logic [1:0] rsp_top_material_ff;
   logic [7:0] eval_surface, eval_bottom;
   logic [1:0] eval_material;

   logic          advance, take, in_map, step, primed, last, wrap, out_wrap, csr_write;
   logic [CW-1:0] col_cur;
   logic [WW-1:0] col_inc, out_col_inc;
   logic [15:0]   product;
   logic [7:0]    sample_v, top_a;

   // clamped extents
   always_comb begin
      if (map_width_ff == 11'd0)             w_eff = WW'(1);
      else if (int'(map_width_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else                                   w_eff = WW'(map_width_ff);
      if (map_height_ff == 11'd0)       h_eff = 11'd1;
      else if (map_height_ff > ROW_LIMIT) h_eff = ROW_LIMIT;
      else                              h_eff = map_height_ff;
   end

   // handshake
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;
   assign take      = req_valid && req_ready;
   assign in_map    = row_ff < h_eff;
   assign step      = take && !(in_map && req_opcode == OP_FLUSH);
   assign csr_write = csr_valid && csr_ready &&
                      (csr_index == REG_MAP_WIDTH || csr_index == REG_MAP_HEIGHT ||
                       csr_index == REG_HEIGHT_SCALE);

   // position bookkeeping
   assign col_cur     = (WW'(col_ff) >= w_eff) ? '0 : col_ff;
   assign col_inc     = WW'(col_cur) + WW'(1);
   assign wrap        = col_inc >= w_eff;
   assign out_col_inc = WW'(out_col_ff) + WW'(1);
   assign out_wrap    = out_col_inc >= w_eff;
   assign primed      = row_ff >= 11'd2 || (row_ff == 11'd1 && col_cur != '0);
   assign last        = (WW'(out_col_ff) == w_eff - WW'(1)) &&
                        ({1'b0, out_row_ff} == h_eff - 11'd1);

   assign border_in.skip_left   = out_col_ff == '0;
   assign border_in.skip_right  = out_wrap;
   assign border_in.skip_top    = out_row_ff == 10'd0;
   assign border_in.skip_bottom = ({1'b0, out_row_ff} + 11'd1) >= h_eff;

   // scaled height, zero while draining
   assign product  = req_height_sample * height_scale_ff;
   assign sample_v = in_map ? product[15:8] : 8'd0;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff    <= MAP_WIDTH_RESET;
         map_height_ff   <= MAP_HEIGHT_RESET;
         height_scale_ff <= HEIGHT_SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAP_WIDTH:    map_width_ff    <= csr_data;
            REG_MAP_HEIGHT:   map_height_ff   <= csr_data;
            REG_HEIGHT_SCALE: height_scale_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // raster counters; a register write or the frame's last result restarts
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         col_ff     <= '0;
         row_ff     <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (step) begin
         if (primed && last) begin
            col_ff     <= '0;
            row_ff     <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else begin
            col_ff <= wrap ? '0 : col_inc[CW-1:0];
            row_ff <= row_ff + {10'd0, wrap};
            if (primed) begin
               out_col_ff <= out_wrap ? '0 : out_col_inc[CW-1:0];
               out_row_ff <= out_row_ff + {9'd0, out_wrap};
            end
         end
      end
   end

   // newest row buffer: read then overwrite at the input column
   always_ff @(posedge clock) begin
      if (step) begin
         prev_rd_ff          <= prev_mem[col_cur];
         older_rd_ff         <= older_mem[col_cur];
         prev_mem[col_cur]   <= sample_v;
      end
   end

   // older row buffer takes the row that stage A just read
   always_ff @(posedge clock) begin
      if (advance && a_valid_ff) older_mem[a_col_ff] <= prev_rd_ff;
   end

   // stage A control
   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else if (advance) a_valid_ff <= step;
   end

   // stage A payload; forward the older row write that lands on the same column
   always_ff @(posedge clock) begin
      if (step) begin
         a_col_ff      <= col_cur;
         a_v_ff        <= sample_v;
         a_primed_ff   <= primed;
         a_last_ff     <= last;
         a_x_ff        <= 10'(out_col_ff);
         a_z_ff        <= out_row_ff;
         a_border_ff   <= border_in;
         a_fwd_ff      <= a_valid_ff && (a_col_ff == col_cur);
         a_fwd_data_ff <= prev_rd_ff;
      end
   end

   assign top_a = a_fwd_ff ? a_fwd_data_ff : older_rd_ff;

   // window shift
   always_comb begin
      window_in      = window_ff;
      window_in[5:0] = window_ff[8:3];
      window_in[6]   = top_a;
      window_in[7]   = prev_rd_ff;
      window_in[8]   = a_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) window_ff <= '0;
      else if (advance && a_valid_ff) window_ff <= window_in;
   end

   hcwe_column_eval u_eval (
      .window         (window_in),
      .border         (a_border_ff),
      .surface_height (eval_surface),
      .wall_bottom    (eval_bottom),
      .top_material   (eval_material)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= a_valid_ff && a_primed_ff;
   end

   always_ff @(posedge clock) begin
      if (advance && a_valid_ff && a_primed_ff) begin
         rsp_col_x_ff          <= a_x_ff;
         rsp_row_z_ff          <= a_z_ff;
         rsp_surface_height_ff <= eval_surface;
         rsp_wall_bottom_ff    <= eval_bottom;
         rsp_top_material_ff   <= eval_material;
         rsp_frame_last_ff     <= a_last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_col_x          = rsp_col_x_ff;
   assign rsp_row_z          = rsp_row_z_ff;
   assign rsp_surface_height = rsp_surface_height_ff;
   assign rsp_wall_bottom    = rsp_wall_bottom_ff;
   assign rsp_top_material   = rsp_top_material_ff;
   assign rsp_frame_last     = rsp_frame_last_ff;

   // checks
   `HCWE_ASSERT_NOW(a_bottom_le_surface, clock, reset, rsp_valid_ff,
      rsp_wall_bottom_ff <= rsp_surface_height_ff, "wall bottom above surface")
   `HCWE_ASSERT_NOW(a_dirt_level, clock, reset, rsp_valid_ff,
      (rsp_top_material_ff == MAT_DIRT) == (rsp_surface_height_ff == STONE_LEVEL),
      "dirt material off the stone level")
   `HCWE_ASSERT_NOW(a_last_restarts, clock, reset, a_valid_ff && a_primed_ff && a_last_ff,
      row_ff == 11'd0 && col_ff == '0 && out_row_ff == 10'd0, "frame end did not restart")
   `HCWE_ASSERT_NEXT(a_rsp_needs_stage, clock, reset, !a_valid_ff && advance,
      !rsp_valid_ff, "result without a staged word")

endmodule
